// ----- rtl/core/mcct_pkg.sv -----
// Shared types, constants and tables for the marching-cubes cell triangulator.
// No dependencies.
package mcct_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NCANON      = 24;

    typedef logic [3:0] edge_t;

    typedef struct packed {
        logic [7:0] cube_case;
        logic       found;
        logic [4:0] canon;
        logic [5:0] xform;
    } job_t;

    localparam logic [7:0] CANON_PAT [NCANON] = '{
        8'h00, 8'h10, 8'h30, 8'h50, 8'h23, 8'h33, 8'hA3, 8'h5A,
        8'h1B, 8'h2B, 8'h14, 8'h34, 8'hA4, 8'h96, 8'h17, 8'h3B,
        8'h3D, 8'h3F, 8'h5B, 8'h7B, 8'h7D, 8'h7F, 8'hFF, 8'h00};
    localparam logic CANON_EXTRA [NCANON] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    localparam logic [2:0] CANON_N [NCANON] = '{
        3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3,
        3'd5, 3'd2, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0, 3'd0};
    localparam logic [59:0] CANON_E [NCANON] = '{
        60'h0,
        {12'h4B8, 48'h0},
        {24'h4B9_495, 36'h0},
        {24'h4B8_69A, 36'h0},
        {36'h489_493_391, 24'h0},
        {24'hB13_B91, 36'h0},
        {48'h489_493_391_B7A, 12'h0},
        {48'hB84_051_273_69A, 12'h0},
        {48'hB27_B82_281_185, 12'h0},
        {48'h748_781_712_891, 12'h0},
        {24'hB84_621, 36'h0},
        {36'h621_B94_495, 24'h0},
        {36'h621_AB7_895, 24'h0},
        {48'h206_605_7A4_4A8, 12'h0},
        {48'hB83_386_685_362, 12'h0},
        {36'h7B9_791_712, 24'h0},
        60'h160_6B0_0B9_095_7B6,
        {24'h7B9_796, 36'h0},
        60'hB87_782_285_251_9A6,
        {48'h7B2_2B1_1BA_1A6, 12'h0},
        {24'h7BA_015, 36'h0},
        {12'h7BA, 48'h0},
        60'h0,
        60'h0};

    localparam edge_t EDGE_RX [12] = '{4'd8, 4'd5, 4'd0, 4'd4, 4'd11, 4'd9,
                                       4'd1, 4'd3, 4'd10, 4'd6, 4'd2, 4'd7};
    localparam edge_t EDGE_RY [12] = '{4'd5, 4'd9, 4'd6, 4'd1, 4'd0, 4'd8,
                                       4'd10, 4'd2, 4'd4, 4'd11, 4'd7, 4'd3};
    localparam edge_t EDGE_RZ [12] = '{4'd3, 4'd0, 4'd1, 4'd2, 4'd7, 4'd4,
                                       4'd5, 4'd6, 4'd11, 4'd8, 4'd9, 4'd10};
    localparam logic [2:0] BIT_RX [8] = '{3'd3, 3'd2, 3'd6, 3'd7, 3'd0, 3'd1, 3'd5, 3'd4};
    localparam logic [2:0] BIT_RY [8] = '{3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6};
    localparam logic [2:0] BIT_RZ [8] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4};

    typedef enum logic [1:0] {ROT_Y, ROT_Z, ROT_X} rot_t;

    function automatic logic [7:0] perm_bits(input logic [7:0] idx, input rot_t r);
        logic [7:0] o;
        o = '0;
        for (int i = 0; i < 8; i++) begin
            if (idx[i]) begin
                unique case (r)
                    ROT_Y: o[BIT_RY[i]] = 1'b1;
                    ROT_Z: o[BIT_RZ[i]] = 1'b1;
                    default: o[BIT_RX[i]] = 1'b1;
                endcase
            end
        end
        return o;
    endfunction

    // Forward transform of an index: lead rotations, x rotations, optional inversion.
    function automatic logic [7:0] xform_index(input logic [7:0] idx, input logic [5:0] t);
        logic [4:0] r;
        logic [2:0] g;
        logic [1:0] x;
        logic [7:0] v;
        r = (t >= 6'd24) ? 5'(t - 6'd24) : t[4:0];
        g = 3'(r >> 2);
        x = r[1:0];
        v = idx;
        if (g >= 3'd1 && g <= 3'd3) v = perm_bits(v, ROT_Y);
        if (g >= 3'd2 && g <= 3'd3) v = perm_bits(v, ROT_Y);
        if (g == 3'd3) v = perm_bits(v, ROT_Y);
        if (g >= 3'd4) v = perm_bits(v, ROT_Z);
        if (g == 3'd5) v = perm_bits(v, ROT_Z);
        if (g == 3'd5) v = perm_bits(v, ROT_Z);
        if (x >= 2'd1) v = perm_bits(v, ROT_X);
        if (x >= 2'd2) v = perm_bits(v, ROT_X);
        if (x == 2'd3) v = perm_bits(v, ROT_X);
        if (t >= 6'd24) v = ~v;
        return v;
    endfunction

    function automatic edge_t map_edge(input edge_t e, input rot_t r);
        edge_t o;
        o = e;
        if (e < 4'd12) begin
            unique case (r)
                ROT_Y: o = EDGE_RY[e];
                ROT_Z: o = EDGE_RZ[e];
                default: o = EDGE_RX[e];
            endcase
        end
        return o;
    endfunction

    // Map a canonical edge back through transform t (steps applied in reverse).
    function automatic edge_t unxform_edge(input edge_t e, input logic [5:0] t);
        logic [4:0] r;
        logic [2:0] g;
        logic [1:0] x;
        edge_t v;
        r = (t >= 6'd24) ? 5'(t - 6'd24) : t[4:0];
        g = 3'(r >> 2);
        x = r[1:0];
        v = e;
        if (x >= 2'd1) v = map_edge(v, ROT_X);
        if (x >= 2'd2) v = map_edge(v, ROT_X);
        if (x == 2'd3) v = map_edge(v, ROT_X);
        if (g >= 3'd1 && g <= 3'd3) v = map_edge(v, ROT_Y);
        if (g >= 3'd2 && g <= 3'd3) v = map_edge(v, ROT_Y);
        if (g == 3'd3) v = map_edge(v, ROT_Y);
        if (g >= 3'd4) v = map_edge(v, ROT_Z);
        if (g == 3'd5) v = map_edge(v, ROT_Z);
        if (g == 3'd5) v = map_edge(v, ROT_Z);
        return v;
    endfunction

endpackage

// ----- rtl/core/mcct_front.sv -----
// Front end: thresholds corners and searches transforms one per cycle.
// Depends on mcct_pkg.
module mcct_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [15:0]                     iso_level,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mcct_pkg::SAMPLE_BITS-1:0] samples [8],
    output logic                            job_valid,
    input  logic                            job_stall,
    output mcct_pkg::job_t                  job
);
    import mcct_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2, S_DONE} state_t;

    state_t     state_reg, state_next;
    logic [7:0] idx_reg, idx_next;
    logic [5:0] t_reg, t_next;
    job_t       job_reg, job_next;

    logic [7:0] cls;
    logic [7:0] tidx;
    logic       hit;
    logic [4:0] hit_n;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            cls[i] = (32'(samples[i]) > 32'(iso_level));
    end

    always_comb
    begin
        tidx  = xform_index(idx_reg, t_reg);
        hit   = 1'b0;
        hit_n = '0;
        for (int i = NCANON - 1; i >= 0; i--) begin
            if (CANON_PAT[i] == tidx && (state_reg == S_PASS1 || !CANON_EXTRA[i])) begin
                hit   = 1'b1;
                hit_n = 5'(i);
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign job_valid = (state_reg == S_DONE);
    assign job       = job_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        t_next     = t_reg;
        job_next   = job_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    idx_next = cls;
                    t_next   = '0;
                    job_next = '{cube_case: cls, found: 1'b1, canon: 5'd0, xform: 6'd0};
                    state_next = (cls == 8'h00 || cls == 8'hFF) ? S_DONE : S_PASS1;
                end
            end
            S_PASS1, S_PASS2:
            begin
                if (hit) begin
                    job_next.canon = hit_n;
                    job_next.xform = t_reg;
                    state_next     = S_DONE;
                end else if (state_reg == S_PASS1 && t_reg == 6'd23) begin
                    t_next     = '0;
                    state_next = S_PASS2;
                end else if (state_reg == S_PASS2 && t_reg == 6'd47) begin
                    job_next.found = 1'b0;
                    state_next     = S_DONE;
                end else begin
                    t_next = t_reg + 6'd1;
                end
            end
            S_DONE:
            begin
                if (!job_stall) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        t_reg   <= t_next;
        job_reg <= job_next;
    end

endmodule

// ----- rtl/core/mcct_queue.sv -----
// Two-entry queue carrying jobs, matched or not, from front to back end.
// Depends on mcct_pkg.
module mcct_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_stall,
    input  mcct_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_stall,
    output mcct_pkg::job_t rd_data
);
    import mcct_pkg::*;

    job_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

endmodule

// ----- rtl/core/mcct_back.sv -----
// Back end: one result per cycle unless stalled; edges undo the transform.
// Depends on mcct_pkg.
module mcct_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_stall,
    input  mcct_pkg::job_t job,
    output logic           out_valid,
    input  logic           stall,
    output logic [3:0]     edge_a,
    output logic [3:0]     edge_b,
    output logic [3:0]     edge_c,
    output logic           has_triangle,
    output logic           case_found,
    output logic [7:0]     cube_case,
    output logic           last_of_cube
);
    import mcct_pkg::*;

    logic [2:0]  tri_reg, tri_next;
    logic [2:0]  ntri;
    logic [11:0] raw;
    edge_t       ea, eb, ec;
    logic        inv;
    logic        take;
    logic        valid_reg;
    logic [3:0]  ea_reg, eb_reg, ec_reg;
    logic        has_reg, found_reg, last_reg;
    logic [7:0]  case_reg;
    logic        out_free;

    assign ntri = job.found ? CANON_N[job.canon] : 3'd0;
    assign raw  = CANON_E[job.canon][59 - 12 * tri_reg -: 12];
    assign inv  = (job.xform >= 6'd24);
    assign ea   = unxform_edge(raw[11:8], job.xform);
    assign eb   = unxform_edge(raw[7:4], job.xform);
    assign ec   = unxform_edge(raw[3:0], job.xform);

    assign out_free  = !valid_reg || !stall;
    assign take      = job_valid && out_free;
    assign job_stall = !(take && (ntri == 3'd0 || tri_reg + 3'd1 == ntri));
    assign tri_next  = (take && !job_stall) ? 3'd0 : (take ? tri_reg + 3'd1 : tri_reg);

    assign out_valid    = valid_reg;
    assign edge_a       = ea_reg;
    assign edge_b       = eb_reg;
    assign edge_c       = ec_reg;
    assign has_triangle = has_reg;
    assign case_found   = found_reg;
    assign cube_case    = case_reg;
    assign last_of_cube = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            tri_reg   <= 3'd0;
        end else begin
            tri_reg <= tri_next;
            if (out_free) valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            has_reg   <= (ntri != 3'd0);
            found_reg <= job.found;
            case_reg  <= job.cube_case;
            last_reg  <= !job_stall;
            if (ntri == 3'd0) begin
                ea_reg <= '0;
                eb_reg <= '0;
                ec_reg <= '0;
            end else begin
                // inversion swaps the first two vertices
                ea_reg <= inv ? eb : ea;
                eb_reg <= inv ? ea : eb;
                ec_reg <= ec;
            end
        end
    end

endmodule

// ----- rtl/core/marching_cubes_cell_triangulator_top.sv -----
// Marching-cubes cell triangulator: corner samples in, triangle edge triples out.
// Depends on mcct_pkg, mcct_front, mcct_queue, mcct_back.
//
// Each transfer on the input carries the eight corner samples of one cube. The
// front end compares each sample with iso_level (strictly greater sets the
// corner's bit of cube_case), then walks the transform search one candidate per
// cycle: up to 24 rotations against all canonical cases, then up to 48
// rotation/inversion transforms against the regular ones. Empty and full cubes
// skip the search. The front end takes the next cube only after its job is handed
// on. Jobs, matched or not, go through a two-entry queue to the back end, which
// transfers one result per cycle while out_stall is low (1 to 5 results per
// cube, last_of_cube marking the final one) from a registered output, so the
// back end drains while the front end searches the next cube. Write
// iso_level only while the block is idle.
module marching_cubes_cell_triangulator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] corner_0,
    input  logic [15:0] corner_1,
    input  logic [15:0] corner_2,
    input  logic [15:0] corner_3,
    input  logic [15:0] corner_4,
    input  logic [15:0] corner_5,
    input  logic [15:0] corner_6,
    input  logic [15:0] corner_7,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  edge_a,
    output logic [3:0]  edge_b,
    output logic [3:0]  edge_c,
    output logic        has_triangle,
    output logic        case_found,
    output logic [7:0]  cube_case,
    output logic        last_of_cube
);
    import mcct_pkg::*;

    logic [15:0]            iso_reg;
    logic [SAMPLE_BITS-1:0] samples [8];
    logic                   fq_valid, fq_stall, qb_valid, qb_stall;
    job_t                   fq_job, qb_job;

    // samples are taken in their low SAMPLE_BITS bits
    assign samples[0] = SAMPLE_BITS'(corner_0);
    assign samples[1] = SAMPLE_BITS'(corner_1);
    assign samples[2] = SAMPLE_BITS'(corner_2);
    assign samples[3] = SAMPLE_BITS'(corner_3);
    assign samples[4] = SAMPLE_BITS'(corner_4);
    assign samples[5] = SAMPLE_BITS'(corner_5);
    assign samples[6] = SAMPLE_BITS'(corner_6);
    assign samples[7] = SAMPLE_BITS'(corner_7);

    // threshold register, reset to mid scale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            iso_reg <= 16'h8000;
        end else if (cfg_we) begin
            iso_reg <= cfg_wdata;
        end
    end

    mcct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .iso_level (iso_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .samples   (samples),
        .job_valid (fq_valid),
        .job_stall (fq_stall),
        .job       (fq_job)
    );

    mcct_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_data  (fq_job),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_data  (qb_job)
    );

    mcct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (qb_valid),
        .job_stall    (qb_stall),
        .job          (qb_job),
        .out_valid    (out_valid),
        .stall        (out_stall),
        .edge_a       (edge_a),
        .edge_b       (edge_b),
        .edge_c       (edge_c),
        .has_triangle (has_triangle),
        .case_found   (case_found),
        .cube_case    (cube_case),
        .last_of_cube (last_of_cube)
    );

endmodule

// ----- sim/marching_cubes_cell_triangulator_top_test.sv -----
// Self-checking testbench for marching_cubes_cell_triangulator_top.
// Depends on the RTL top level only; carries its own case-table search for the expected triangles.
module marching_cubes_cell_triangulator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Steps of one cube transform, applied in slot order 0..6.
    typedef enum int {STEP_NOP, STEP_INV, STEP_RX, STEP_RY, STEP_RZ} step_e;

    typedef struct packed {
        logic [7:0][15:0] smp;
    } cube_t;

    typedef struct packed {
        logic [3:0] ea;
        logic [3:0] eb;
        logic [3:0] ec;
        logic       has_tri;
        logic       found;
        logic [7:0] cidx;
        logic       last;
    } tri_t;

    localparam int IDLE_PCT   = 38;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] corner_0, corner_1, corner_2, corner_3;
    logic [15:0] corner_4, corner_5, corner_6, corner_7;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  edge_a, edge_b, edge_c;
    logic        has_triangle;
    logic        case_found;
    logic [7:0]  cube_case;
    logic        last_of_cube;

    marching_cubes_cell_triangulator_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .corner_0(corner_0), .corner_1(corner_1), .corner_2(corner_2), .corner_3(corner_3),
        .corner_4(corner_4), .corner_5(corner_5), .corner_6(corner_6), .corner_7(corner_7),
        .out_valid(out_valid), .out_stall(out_stall),
        .edge_a(edge_a), .edge_b(edge_b), .edge_c(edge_c), .has_triangle(has_triangle),
        .case_found(case_found), .cube_case(cube_case), .last_of_cube(last_of_cube)
    );

    // Corner and edge permutations of the three quarter turns.
    int rx_bit [8]  = '{3, 2, 6, 7, 0, 1, 5, 4};
    int ry_bit [8]  = '{4, 0, 3, 7, 5, 1, 2, 6};
    int rz_bit [8]  = '{1, 2, 3, 0, 5, 6, 7, 4};
    int rx_edge [12] = '{8, 5, 0, 4, 11, 9, 1, 3, 10, 6, 2, 7};
    int ry_edge [12] = '{5, 9, 6, 1, 0, 8, 10, 2, 4, 11, 7, 3};
    int rz_edge [12] = '{3, 0, 1, 2, 7, 4, 5, 6, 11, 8, 9, 10};
    int lead_cnt [6] = '{0, 1, 2, 3, 1, 3};

    // Canonical cases: pattern, extra flag, triangle count, edges (first at the top nibble).
    logic [7:0] canon_pat [24] = '{
        8'h00, 8'h10, 8'h30, 8'h50, 8'h23, 8'h33, 8'hA3, 8'h5A,
        8'h1B, 8'h2B, 8'h14, 8'h34, 8'hA4, 8'h96, 8'h17, 8'h3B,
        8'h3D, 8'h3F, 8'h5B, 8'h7B, 8'h7D, 8'h7F, 8'hFF, 8'h00};
    logic canon_xtra [24] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                              1, 1, 1, 1, 1, 1, 1, 1};
    int canon_ntri [24] = '{0, 1, 2, 2, 3, 2, 4, 4, 4, 4, 2, 3, 3, 4, 4, 3,
                            5, 2, 5, 4, 2, 1, 0, 0};
    logic [59:0] canon_edges [24] = '{
        60'h0,
        60'h4B8_000_000_000_000,
        60'h4B9_495_000_000_000,
        60'h4B8_69A_000_000_000,
        60'h489_493_391_000_000,
        60'hB13_B91_000_000_000,
        60'h489_493_391_B7A_000,
        60'hB84_051_273_69A_000,
        60'hB27_B82_281_185_000,
        60'h748_781_712_891_000,
        60'hB84_621_000_000_000,
        60'h621_B94_495_000_000,
        60'h621_AB7_895_000_000,
        60'h206_605_7A4_4A8_000,
        60'hB83_386_685_362_000,
        60'h7B9_791_712_000_000,
        60'h160_6B0_0B9_095_7B6,
        60'h7B9_796_000_000_000,
        60'hB87_782_285_251_9A6,
        60'h7B2_2B1_1BA_1A6_000,
        60'h7BA_015_000_000_000,
        60'h7BA_000_000_000_000,
        60'h0,
        60'h0};

    cube_t       pending_cubes [$];
    tri_t        expected_tris [$];
    logic [15:0] iso_copy;
    bit          calm;
    bit          hold_input;
    bit          failed;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Step in slot k of transform t: lead rotations, x rotations, then inversion.
    function automatic step_e step_of(int t, int k);
        int r;
        int g;
        r = t % 24;
        g = r / 4;
        if (k < 3)
            return (k < lead_cnt[g]) ? ((g >= 4) ? STEP_RZ : STEP_RY) : STEP_NOP;
        if (k < 6)
            return ((k - 3) < (r % 4)) ? STEP_RX : STEP_NOP;
        return (t >= 24) ? STEP_INV : STEP_NOP;
    endfunction

    function automatic logic [7:0] turn_index(logic [7:0] idx, step_e s);
        logic [7:0] o;
        o = '0;
        if (s == STEP_INV)
            return ~idx;
        if (s == STEP_NOP)
            return idx;
        for (int i = 0; i < 8; i++)
            if (idx[i])
                o[(s == STEP_RX) ? rx_bit[i] : (s == STEP_RY) ? ry_bit[i] : rz_bit[i]] = 1'b1;
        return o;
    endfunction

    function automatic logic [3:0] turn_edge(logic [3:0] e, step_e s);
        if (e >= 12 || s == STEP_NOP || s == STEP_INV)
            return e;
        return 4'((s == STEP_RX) ? rx_edge[e] : (s == STEP_RY) ? ry_edge[e] : rz_edge[e]);
    endfunction

    // Canonical entry matched by idx under transform t, or -1.
    function automatic int canon_hit(logic [7:0] idx, int t, bit with_extra);
        logic [7:0] v;
        v = idx;
        for (int k = 0; k < 7; k++)
            v = turn_index(v, step_of(t, k));
        for (int i = 0; i < 24; i++)
            if ((with_extra || !canon_xtra[i]) && canon_pat[i] == v)
                return i;
        return -1;
    endfunction

    // Classify one cube, search the case table and queue its triangles.
    task automatic predict_triangles(cube_t cb);
        logic [7:0] idx;
        int         hit;
        int         tx;
        int         ntri;
        bit         found;
        tri_t       tr;
        logic [3:0] tv [3];
        logic [3:0] sw;
        idx = '0;
        hit = -1;
        tx = 0;
        ntri = 0;
        found = 0;
        for (int i = 0; i < 8; i++)
            if (cb.smp[i] > iso_copy)
                idx[i] = 1'b1;
        if (idx == 8'h00 || idx == 8'hFF)
        begin
            found = 1;
        end
        else
        begin
            for (int t = 0; t < 24 && hit < 0; t++)
            begin
                hit = canon_hit(idx, t, 1);
                tx = t;
            end
            for (int t = 0; t < 48 && hit < 0; t++)
            begin
                hit = canon_hit(idx, t, 0);
                tx = t;
            end
            if (hit >= 0)
            begin
                found = 1;
                ntri = canon_ntri[hit];
            end
        end
        if (ntri == 0)
        begin
            tr = '{ea: 0, eb: 0, ec: 0, has_tri: 0, found: found, cidx: idx, last: 1};
            expected_tris.push_back(tr);
        end
        for (int j = 0; j < ntri; j++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                tv[v] = canon_edges[hit][59 - 12 * j - 4 * v -: 4];
                for (int k = 5; k >= 0; k--)
                    tv[v] = turn_edge(tv[v], step_of(tx, k));
            end
            // inversion flips the winding
            if (step_of(tx, 6) == STEP_INV)
            begin
                sw = tv[0];
                tv[0] = tv[1];
                tv[1] = sw;
            end
            tr = '{ea: tv[0], eb: tv[1], ec: tv[2], has_tri: 1, found: 1, cidx: idx,
                   last: (j == ntri - 1)};
            expected_tris.push_back(tr);
        end
    endtask

    // Driver: hold a stalled transfer, otherwise offer the next pending cube or idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_triangles(pending_cubes[0]);
                void'(pending_cubes.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_cubes.size() > 0 && !hold_input
                    && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    corner_0 <= pending_cubes[0].smp[0];
                    corner_1 <= pending_cubes[0].smp[1];
                    corner_2 <= pending_cubes[0].smp[2];
                    corner_3 <= pending_cubes[0].smp[3];
                    corner_4 <= pending_cubes[0].smp[4];
                    corner_5 <= pending_cubes[0].smp[5];
                    corner_6 <= pending_cubes[0].smp[6];
                    corner_7 <= pending_cubes[0].smp[7];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            failed = 1;
        end
    endtask

    // Monitor: random back-pressure, compare each result transfer with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        tri_t ex;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tris.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual case %0d",
                             $time, cube_case);
                    failed = 1;
                end
                else
                begin
                    ex = expected_tris.pop_front();
                    check_field("edge_a", ex.ea, edge_a);
                    check_field("edge_b", ex.eb, edge_b);
                    check_field("edge_c", ex.ec, edge_c);
                    check_field("has_triangle", ex.has_tri, has_triangle);
                    check_field("case_found", ex.found, case_found);
                    check_field("cube_case", ex.cidx, cube_case);
                    check_field("last_of_cube", ex.last, last_of_cube);
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: count cycles without any transfer on either side; end as failed at STALL_LIMIT.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_iso(logic [15:0] lvl);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= lvl;
        iso_copy = lvl;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_cubes.size() > 0 || expected_tris.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Pick a sample on the requested side of the iso level, often right at the boundary.
    function automatic logic [15:0] pick_sample(bit above);
        bit edgy;
        edgy = ($urandom_range(3) == 0);
        if (above && iso_copy != 16'hFFFF)
            return edgy ? (($urandom_range(1) != 0) ? iso_copy + 16'd1 : 16'hFFFF)
                        : 16'($urandom_range(65535, iso_copy + 1));
        return edgy ? (($urandom_range(1) != 0) ? iso_copy : 16'h0000)
                    : 16'($urandom_range(iso_copy, 0));
    endfunction

    task automatic add_cube_case(logic [7:0] idx);
        cube_t cb;
        for (int i = 0; i < 8; i++)
            cb.smp[i] = pick_sample(idx[i]);
        pending_cubes.push_back(cb);
    endtask

    task automatic add_flat(logic [15:0] v);
        cube_t cb;
        for (int i = 0; i < 8; i++)
            cb.smp[i] = v;
        pending_cubes.push_back(cb);
    endtask

    // Mostly cubes with a chosen corner pattern, some fully random samples.
    task automatic add_random_cubes(int count);
        cube_t cb;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(4) == 0)
            begin
                for (int i = 0; i < 8; i++)
                    cb.smp[i] = 16'($urandom);
                pending_cubes.push_back(cb);
            end
            else
            begin
                add_cube_case(8'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [15:0] iso_plan [5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        corner_0 = '0; corner_1 = '0; corner_2 = '0; corner_3 = '0;
        corner_4 = '0; corner_5 = '0; corner_6 = '0; corner_7 = '0;
        iso_copy = 16'd32768;
        calm = 0;
        hold_input = 0;
        failed = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: flat cubes on both sides of the threshold, single corners, classic cases.
        write_iso(16'd32768);
        add_flat(16'h0000);
        add_flat(16'hFFFF);
        add_flat(16'd32768);
        add_flat(16'd32769);
        for (int i = 0; i < 8; i++)
            add_cube_case(8'(1 << i));
        add_cube_case(8'h5A);
        add_cube_case(8'hA5);
        add_cube_case(8'h3C);
        add_cube_case(8'h96);
        add_cube_case(8'h69);
        add_cube_case(8'h7E);
        add_cube_case(8'h81);
        add_cube_case(8'hC3);
        add_cube_case(8'h24);
        add_cube_case(8'hFE);
        wait_drained();

        // Random phases at the extremes and at random levels.
        iso_plan = '{16'h0000, 16'hFFFF, 16'd1, 16'($urandom), 16'($urandom)};
        for (int p = 0; p < 5; p++)
        begin
            write_iso(iso_plan[p]);
            calm = (p == 3);
            add_random_cubes(13);
            if (p == 4)
            begin
                // let the block run dry before the rest of the phase
                hold_input = 1;
                while (expected_tris.size() > 0 || (in_valid && !in_stall))
                    @(negedge clk);
                hold_input = 0;
            end
            add_random_cubes(13);
            wait_drained();
        end
        calm = 0;

        if (failed)
        begin
            $display("Test completed with failures");
        end
        else
        begin
            $display("Test completed successfully");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mcct_pkg.sv
rtl/core/mcct_front.sv
rtl/core/mcct_queue.sv
rtl/core/mcct_back.sv
rtl/core/marching_cubes_cell_triangulator_top.sv
sim/marching_cubes_cell_triangulator_top_test.sv
